// ===== rtl/core/rsca_pkg.sv =====
package rsca_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned ENT_W       = 5;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ITER_W      = $clog2(DATA_W);

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK   = 3'd0;
  localparam logic [STAT_W-1:0] ST_FEW  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVF  = 3'd3;
  localparam logic [STAT_W-1:0] ST_DIV0 = 3'd4;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] operand;
  } rsca_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] top_value;
    logic [ENT_W-1:0]         entries;
  } rsca_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP1,
    S_POP2,
    S_POP3,
    S_ITER,
    S_SIGN,
    S_READ,
    S_DONE
  } rsca_state_e;

endpackage

// ===== rtl/core/rpn_stack_checked_alu_top.sv =====
// Checked RPN calculator core: a 16-deep stack of signed 32-bit values with push, add,
// subtract, multiply and divide (truncating toward zero). Each input beat yields exactly
// one result beat carrying a status (ok, not enough values, stack full, overflow, divide
// by zero), the new stack top (zero when empty) and the entry count. Errors push nothing
// but keep the pops already done: add/sub with one entry eat it, an overflow eats both
// operands, a divide by zero eats only the divisor, mul/div with fewer than two entries
// eat nothing. Codes 5 to 7 leave the stack alone and report ok. One item is worked at a
// time and in_stall_o stays high until its result sits in the output register. Push, unknown
// codes and operations on a short stack go straight to the top read-back (S_READ) and
// S_DONE; a divide by zero or add/sub on a lone entry stops after the pops; add and subtract
// use the adder in S_POP3; multiply and divide run the 32-step shift-add / restoring loop on
// the single shared 33-bit adder, then the sign fixup. The two stack reads and the top
// read-back go through the stack RAM's one read port. The next item may enter while a result
// still waits on out_stall_i.
module rpn_stack_checked_alu_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rsca_pkg::rsca_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsca_pkg::rsca_out_t out_data_o
);
  import rsca_pkg::*;

  rsca_state_e state_q, state_d;

  // control
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic [ACT_W-1:0]  act_q, act_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [DATA_W-1:0] hi_q, hi_d;
  logic [DATA_W-1:0] lo_q, lo_d;
  logic [DATA_W-1:0] opa_q, opa_d;
  logic              neg_q, neg_d;
  rsca_out_t         out_q, out_d;

  // stack RAM
  logic [DATA_W-1:0] mem_q [STACK_DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  // shared adder
  logic [DATA_W:0] alu_a, alu_b, alu_sum;
  logic            alu_sub;

  logic in_accept;
  logic out_free;
  logic is_mul;
  logic few_check;
  logic qbit;
  logic sign_ovf;

  function automatic logic [DATA_W-1:0] abs_val(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] r;
    r = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
    return r;
  endfunction

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_mul      = (act_q == ACT_MUL);

  // the read port always points at the current top
  assign rd_addr = IDX_W'(cnt_q - CNT_W'(1));

  assign few_check = ((in_data_i.action == ACT_MUL || in_data_i.action == ACT_DIV)
                      && cnt_q < CNT_W'(2)) || (cnt_q == '0);

  // magnitude of quotient or product must fit the signed range
  assign sign_ovf = (is_mul && hi_q != '0) ||
                    (lo_q[DATA_W-1] && !(neg_q && lo_q[DATA_W-2:0] == '0));

  assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + (DATA_W+1)'(alu_sub);

  // operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_POP3: begin
        alu_a   = {rd_q[DATA_W-1], rd_q};
        alu_b   = {top_q[DATA_W-1], top_q};
        alu_sub = (act_q == ACT_SUB);
      end
      S_ITER: begin
        if (is_mul) begin
          alu_a = {1'b0, hi_q};
          alu_b = lo_q[0] ? {1'b0, opa_q} : '0;
        end else begin
          alu_a   = {1'b0, hi_q[DATA_W-2:0], lo_q[DATA_W-1]};
          alu_b   = {1'b0, opa_q};
          alu_sub = 1'b1;
        end
      end
      S_SIGN: begin
        alu_b   = {1'b0, lo_q};
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data_i.action == ACT_PUSH || in_data_i.action > ACT_DIV || few_check) begin
            state_d = S_READ;
          end else begin
            state_d = S_POP1;
          end
        end
      end
      S_POP1: state_d = S_POP2;
      S_POP2: begin
        if ((act_q == ACT_DIV && rd_q == '0) || cnt_q == '0) begin
          state_d = S_READ;
        end else begin
          state_d = S_POP3;
        end
      end
      S_POP3: begin
        if (act_q == ACT_ADD || act_q == ACT_SUB) begin
          state_d = S_READ;
        end else begin
          state_d = S_ITER;
        end
      end
      S_ITER: begin
        if (iter_q == ITER_W'(DATA_W - 1)) begin
          state_d = S_SIGN;
        end
      end
      S_SIGN: state_d = S_READ;
      S_READ: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d       = cnt_q;
    iter_d      = iter_q;
    act_d       = act_q;
    status_d    = status_q;
    top_d       = top_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    opa_d       = opa_q;
    neg_d       = neg_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = IDX_W'(cnt_q);
    wr_data     = alu_sum[DATA_W-1:0];
    qbit        = !alu_sum[DATA_W];
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          act_d    = in_data_i.action;
          status_d = ST_OK;
          case (in_data_i.action)
            ACT_PUSH: begin
              if (cnt_q == CNT_W'(STACK_DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_data = in_data_i.operand;
                cnt_d   = cnt_q + CNT_W'(1);
              end
            end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
              if (few_check) begin
                status_d = ST_FEW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP1: cnt_d = cnt_q - CNT_W'(1);
      S_POP2: begin
        top_d = rd_q;
        if (act_q == ACT_DIV && rd_q == '0) begin
          status_d = ST_DIV0;
        end else if (cnt_q == '0) begin
          status_d = ST_FEW;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_POP3: begin
        if (act_q == ACT_ADD || act_q == ACT_SUB) begin
          if (alu_sum[DATA_W] != alu_sum[DATA_W-1]) begin
            status_d = ST_OVF;
          end else begin
            wr_en = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end else begin
          neg_d  = rd_q[DATA_W-1] ^ top_q[DATA_W-1];
          hi_d   = '0;
          iter_d = '0;
          if (is_mul) begin
            lo_d  = abs_val(top_q);
            opa_d = abs_val(rd_q);
          end else begin
            lo_d  = abs_val(rd_q);
            opa_d = abs_val(top_q);
          end
        end
      end
      S_ITER: begin
        iter_d = iter_q + ITER_W'(1);
        if (is_mul) begin
          hi_d = alu_sum[DATA_W:1];
          lo_d = {alu_sum[0], lo_q[DATA_W-1:1]};
        end else begin
          // restoring step: keep the difference when it did not borrow
          hi_d = qbit ? alu_sum[DATA_W-1:0] : {hi_q[DATA_W-2:0], lo_q[DATA_W-1]};
          lo_d = {lo_q[DATA_W-2:0], qbit};
        end
      end
      S_SIGN: begin
        if (sign_ovf) begin
          status_d = ST_OVF;
        end else begin
          wr_en   = 1'b1;
          wr_data = neg_q ? alu_sum[DATA_W-1:0] : lo_q;
          cnt_d   = cnt_q + CNT_W'(1);
        end
      end
      S_READ: begin
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = status_q;
          out_d.top_value = (cnt_q == '0) ? '0 : rd_q;
          out_d.entries   = ENT_W'(cnt_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    status_q <= status_d;
    top_q    <= top_d;
    hi_q     <= hi_d;
    lo_q     <= lo_d;
    opa_q    <= opa_d;
    neg_q    <= neg_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != S_IDLE)
    else $error("accepted beat did not start work");

  a_idle_holds_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_accept) |=> $stable(cnt_q))
    else $error("stack count moved while idle");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_FULL) |-> out_q.entries == ENT_W'(STACK_DEPTH))
    else $error("stack full reported on a stack that is not full");

endmodule
